>>> src/block_bitmap_file_allocator_core_assert.svh
// Assertion macros for the block allocator core.
// Depends on nothing; included by the top level.
`ifndef BLOCK_BITMAP_FILE_ALLOCATOR_CORE_ASSERT_SVH
`define BLOCK_BITMAP_FILE_ALLOCATOR_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define BBFA_ASSERT_IMP(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define BBFA_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

>>> src/bbfa_pkg.sv
// Package for the block allocator core: operation, status and state codes.
// No dependencies.
package bbfa_pkg;
  localparam int MapBlocksDefault    = 4096;
  localparam int TableEntriesDefault = 64;
  localparam int WordBits            = 32;

  localparam logic [2:0] OP_FORMAT = 3'd0;
  localparam logic [2:0] OP_CREATE = 3'd1;
  localparam logic [2:0] OP_DELETE = 3'd2;
  localparam logic [2:0] OP_GET    = 3'd3;
  localparam logic [2:0] OP_LOOKUP = 3'd4;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND  = 2'd1;
  localparam logic [1:0] ST_NO_SPACE   = 2'd2;
  localparam logic [1:0] ST_TABLE_FULL = 2'd3;

  typedef enum logic [11:0] {
    S_INIT   = 12'b000000000001,
    S_IDLE   = 12'b000000000010,
    S_FIND   = 12'b000000000100,
    S_FWAIT  = 12'b000000001000,
    S_MSCAN  = 12'b000000010000,
    S_MWAIT  = 12'b000000100000,
    S_MARK   = 12'b000001000000,
    S_MRD    = 12'b000010000000,
    S_MWR    = 12'b000100000000,
    S_DECIDE = 12'b001000000000,
    S_RESP   = 12'b010000000000,
    S_FREE   = 12'b100000000000
  } state_t;
endpackage

>>> src/block_bitmap_file_allocator_core.sv
// Top level of the first-fit bitmap block allocator with a file table.
// Depends on bbfa_pkg and block_bitmap_file_allocator_core_assert.svh.
//
//  channel | handshake           | payload
//  in      | in_valid/in_ready   | operation, file_id, req_blocks
//  out     | out_valid/out_ready | status, run_start, block_total
//
// One item at a time. The free map is a memory of 32-bit words, registered read.
// A table entry is checked in states FIND and FWAIT; a map word is read in MWAIT
// and scanned in MSCAN, whole in a create search and 8 bits a cycle in a run
// search; to mark or free a map word it is read in MRD and written in MWR.
// After rst and after each format a clearing pass writes every map word and no
// item is taken. A waiting result holds off the next item.
`include "block_bitmap_file_allocator_core_assert.svh"
module block_bitmap_file_allocator_core #(
  parameter int MAP_BLOCKS    = bbfa_pkg::MapBlocksDefault,
  parameter int TABLE_ENTRIES = bbfa_pkg::TableEntriesDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  operation,
  input  logic [15:0] file_id,
  input  logic [12:0] req_blocks,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [11:0] run_start,
  output logic [12:0] block_total
);
  localparam int WB = bbfa_pkg::WordBits;
  localparam int NW = (MAP_BLOCKS + WB - 1) / WB;
  localparam int WAW = (NW > 1) ? $clog2(NW) : 1;
  localparam int BW = $clog2(MAP_BLOCKS) + 1;   // block number incl. end value
  localparam int EW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int ECW = $clog2(TABLE_ENTRIES + 1);
  localparam int BIW = $clog2(WB);
  localparam int CB = 8;                        // bits per cycle in a run search
  localparam int NCH = WB / CB;
  localparam int CHW = $clog2(NCH);
  localparam int CBW = $clog2(CB);

  // free map memory, one word per address, registered read
  logic [WB-1:0] map_mem [NW];
  logic [WAW-1:0] map_ra, map_wa;
  logic [WB-1:0] map_rd, map_wd;
  logic map_we;
  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_wa] <= map_wd;
    map_rd <= map_mem[map_ra];
  end

  // file table memory: {file_id, start, size}, registered read
  logic [16+BW+12:0] tab_mem [TABLE_ENTRIES];
  logic [EW-1:0] tab_ra, tab_wa;
  logic [16+BW+12:0] tab_rd, tab_wd;
  logic tab_we;
  always_ff @(posedge clk) begin
    if (tab_we) tab_mem[tab_wa] <= tab_wd;
    tab_rd <= tab_mem[tab_ra];
  end
  logic [TABLE_ENTRIES-1:0] valid;

  // lowest free table slot
  logic free_any;
  logic [EW-1:0] free_idx;
  always_comb begin
    free_any = 1'b0; free_idx = '0;
    for (int e = TABLE_ENTRIES - 1; e >= 0; e--)
      if (!valid[e]) begin free_any = 1'b1; free_idx = EW'(e); end
  end

  bbfa_pkg::state_t state;
  logic [2:0]  op;
  logic [15:0] id;
  logic [12:0] cnt;
  logic [ECW-1:0] eidx;
  logic [EW-1:0] hit_e, free_e;
  logic hit_found, free_found;
  logic [WAW:0] widx;
  logic [CHW-1:0] sub;
  logic [BW-1:0] run, last, fstart, fsize;
  logic [BW-1:0] first_free;

  // word initial contents: blocks 0, 1 reserved, blocks beyond map end used
  function automatic logic [WB-1:0] init_word(input logic [WAW-1:0] w);
    logic [WB-1:0] v;
    for (int i = 0; i < WB; i++)
      v[i] = ((int'(w) * WB + i) >= 2) && ((int'(w) * WB + i) < MAP_BLOCKS);
    return v;
  endfunction

  // run scan over one byte of the word per cycle
  logic [CB-1:0] chunk;
  assign chunk = map_rd[int'(sub) * CB +: CB];
  logic [BW-1:0] run_n, last_n;
  logic done_n, any_n;
  logic [BIW-1:0] ff_bit;
  always_comb begin
    run_n = run; last_n = last; done_n = 1'b0; any_n = 1'b0; ff_bit = '0;
    for (int i = WB - 1; i >= 0; i--)
      if (map_rd[i]) begin any_n = 1'b1; ff_bit = BIW'(i); end
    for (int i = 0; i < CB; i++) begin
      if (!done_n) begin
        if (chunk[i]) begin
          run_n = run_n + 1'b1;
          last_n = BW'({widx[WAW-1:0], sub, CBW'(i)});
        end else run_n = '0;
        if (run_n >= BW'(cnt)) done_n = 1'b1;
      end
    end
  end

  logic [BW-1:0] rstart;
  assign rstart = last + 1'b1 - BW'(cnt);
  logic [BW-1:0] fend;
  assign fend = fstart + fsize;

  // mask of bits of word widx in [lo, hi)
  function automatic logic [WB-1:0] span_mask(input logic [WAW-1:0] w,
      input logic [BW-1:0] lo, input logic [BW-1:0] hi);
    logic [WB-1:0] m;
    logic [BW:0] b;
    for (int i = 0; i < WB; i++) begin
      b = (BW+1)'({w, BIW'(i)});
      m[i] = (b >= (BW+1)'(lo)) && (b < (BW+1)'(hi));
    end
    return m;
  endfunction

  assign in_ready = (state == bbfa_pkg::S_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    map_we <= 1'b0;
    tab_we <= 1'b0;
    if (out_valid && out_ready) out_valid <= 1'b0;
    if (rst) begin
      state <= bbfa_pkg::S_INIT;
      widx <= '0;
      valid <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        bbfa_pkg::S_INIT: begin
          map_we <= 1'b1;
          map_wa <= widx[WAW-1:0];
          map_wd <= init_word(widx[WAW-1:0]);
          if (widx == (WAW+1)'(NW - 1)) state <= bbfa_pkg::S_IDLE;
          widx <= widx + 1'b1;
        end
        bbfa_pkg::S_IDLE: begin
          if (in_valid && in_ready) begin
            op <= operation; id <= file_id; cnt <= req_blocks;
            eidx <= '0; hit_found <= 1'b0; free_found <= 1'b0;
            widx <= '0; sub <= '0; run <= '0; last <= '0;
            tab_ra <= '0;
            status <= bbfa_pkg::ST_OK; run_start <= '0; block_total <= '0;
            if (operation == bbfa_pkg::OP_FORMAT) begin
              valid <= '0;
              state <= bbfa_pkg::S_INIT;
              out_valid <= 1'b1;
            end else if (operation == bbfa_pkg::OP_CREATE) begin
              map_ra <= '0;
              state <= bbfa_pkg::S_MWAIT;
            end else if (operation == bbfa_pkg::OP_DELETE ||
                         operation == bbfa_pkg::OP_GET ||
                         operation == bbfa_pkg::OP_LOOKUP) begin
              state <= bbfa_pkg::S_FIND;
            end else out_valid <= 1'b1;
          end
        end
        // table read in flight
        bbfa_pkg::S_FIND: state <= bbfa_pkg::S_FWAIT;
        bbfa_pkg::S_FWAIT: begin
          if (valid[eidx[EW-1:0]] && tab_rd[16+BW+12:BW+13] == id) begin
            hit_found <= 1'b1; hit_e <= eidx[EW-1:0];
            fstart <= BW'(tab_rd[BW+12:13]);
            fsize <= BW'(tab_rd[12:0]);
            state <= bbfa_pkg::S_DECIDE;
          end else if (eidx == ECW'(TABLE_ENTRIES - 1)) state <= bbfa_pkg::S_DECIDE;
          else begin
            eidx <= eidx + 1'b1; tab_ra <= eidx[EW-1:0] + 1'b1;
            state <= bbfa_pkg::S_FIND;
          end
        end
        bbfa_pkg::S_DECIDE: begin
          unique case (op)
            bbfa_pkg::OP_LOOKUP: begin
              if (hit_found) begin
                run_start <= 12'(fstart); block_total <= 13'(fsize);
              end else status <= bbfa_pkg::ST_NOT_FOUND;
              state <= bbfa_pkg::S_RESP;
            end
            bbfa_pkg::OP_DELETE: begin
              if (hit_found) begin
                valid[hit_e] <= 1'b0;
                widx <= (WAW+1)'(fstart >> BIW);
                state <= bbfa_pkg::S_FREE;
              end else begin
                status <= bbfa_pkg::ST_NOT_FOUND; state <= bbfa_pkg::S_RESP;
              end
            end
            bbfa_pkg::OP_GET: begin
              if (!hit_found) begin
                status <= bbfa_pkg::ST_NOT_FOUND; state <= bbfa_pkg::S_RESP;
              end else if (cnt == '0 || 32'(cnt) > 32'(MAP_BLOCKS)) begin
                status <= bbfa_pkg::ST_NO_SPACE; state <= bbfa_pkg::S_RESP;
              end else begin
                map_ra <= '0; state <= bbfa_pkg::S_MWAIT;
              end
            end
            default: begin // create: table slot picked
              if (!free_found) begin
                status <= bbfa_pkg::ST_TABLE_FULL; state <= bbfa_pkg::S_RESP;
              end else begin
                valid[free_e] <= 1'b1;
                tab_we <= 1'b1; tab_wa <= free_e;
                tab_wd <= {id, first_free, 13'd1};
                map_ra <= (WAW)'(first_free >> BIW);
                widx <= (WAW+1)'(first_free >> BIW);
                fstart <= first_free; fsize <= BW'(1);
                run_start <= 12'(first_free); block_total <= 13'd1;
                state <= bbfa_pkg::S_MRD;
              end
            end
          endcase
        end
        bbfa_pkg::S_MWAIT: state <= bbfa_pkg::S_MSCAN;
        bbfa_pkg::S_MSCAN: begin
          if (op == bbfa_pkg::OP_CREATE) begin
            if (any_n) begin
              first_free <= BW'({widx[WAW-1:0], ff_bit});
              state <= bbfa_pkg::S_MARK;
            end else if (widx == (WAW+1)'(NW - 1)) begin
              status <= bbfa_pkg::ST_NO_SPACE; state <= bbfa_pkg::S_RESP;
            end else begin
              widx <= widx + 1'b1; map_ra <= widx[WAW-1:0] + 1'b1;
              state <= bbfa_pkg::S_MWAIT;
            end
          end else begin
            // one byte of the word per cycle; the word stays on map_rd
            run <= run_n; last <= last_n;
            if (done_n) begin
              state <= bbfa_pkg::S_MARK;
            end else if (sub != CHW'(NCH - 1)) begin
              sub <= sub + 1'b1;
            end else if (widx == (WAW+1)'(NW - 1)) begin
              status <= bbfa_pkg::ST_NO_SPACE; state <= bbfa_pkg::S_RESP;
            end else begin
              widx <= widx + 1'b1; map_ra <= widx[WAW-1:0] + 1'b1;
              sub <= '0;
              state <= bbfa_pkg::S_MWAIT;
            end
          end
        end
        bbfa_pkg::S_MARK: begin
          if (op == bbfa_pkg::OP_CREATE) begin
            // free block found; now take the lowest free table slot
            eidx <= '0;
            free_found <= free_any; free_e <= free_idx;
            state <= bbfa_pkg::S_DECIDE;
          end else begin
            fstart <= rstart; fsize <= BW'(cnt);
            tab_we <= 1'b1; tab_wa <= hit_e;
            tab_wd <= {id, rstart, cnt};
            run_start <= 12'(rstart); block_total <= cnt;
            widx <= (WAW+1)'(rstart >> BIW);
            map_ra <= WAW'(rstart >> BIW);
            state <= bbfa_pkg::S_MRD;
          end
        end
        bbfa_pkg::S_MRD: state <= bbfa_pkg::S_MWR;
        bbfa_pkg::S_MWR: begin
          // delete sets the run's bits in this word, the others clear them
          map_we <= 1'b1; map_wa <= widx[WAW-1:0];
          if (op == bbfa_pkg::OP_DELETE)
            map_wd <= map_rd | (span_mask(widx[WAW-1:0], fstart, fend)
                                & init_word(widx[WAW-1:0]));
          else
            map_wd <= map_rd & ~span_mask(widx[WAW-1:0], fstart, fend);
          if ((BW+1)'({widx, BIW'(WB - 1)}) >= (BW+1)'(fend) - 1'b1 ||
              widx == (WAW+1)'(NW - 1))
            state <= bbfa_pkg::S_RESP;
          else begin
            widx <= widx + 1'b1; map_ra <= widx[WAW-1:0] + 1'b1;
            state <= bbfa_pkg::S_MRD;
          end
        end
        bbfa_pkg::S_FREE: begin
          // start the read/write walk at the run's first word
          map_ra <= widx[WAW-1:0];
          state <= bbfa_pkg::S_MRD;
        end
        bbfa_pkg::S_RESP: begin
          out_valid <= 1'b1;
          state <= bbfa_pkg::S_IDLE;
        end
        default: state <= bbfa_pkg::S_IDLE;
      endcase
    end
  end

  `BBFA_ASSERT_IMP(a_one_hot, clk, rst, 1'b1, $onehot(state))
  `BBFA_ASSERT_IMP(a_no_take_busy, clk, rst, in_valid && in_ready, !out_valid)
  `BBFA_ASSERT_NEXT(a_resp_out, clk, rst, state == bbfa_pkg::S_RESP, out_valid)
endmodule
